>>> rtl/sfcm_pkg.sv
// shared types, constants and saturation helper for the stereo fir convolution mix
`default_nettype none

package sfcm_pkg;

    // impulse response and history sizes
    localparam int TAP_ADDR_W = 12;
    localparam int MAX_TAPS   = 1 << TAP_ADDR_W;
    localparam int LEN_W      = TAP_ADDR_W + 1;

    // sample and arithmetic widths
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + TAP_ADDR_W;
    localparam int FRAC_BITS = 15;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int MIX_W     = 16;
    localparam int MIXP_W    = 2 * DIFF_W;
    localparam int WIDE_W    = 32;

    // full-wet mix value (1.0 in Q1.15)
    localparam logic [MIX_W-1:0] MIX_MAX = MIX_W'(1 << FRAC_BITS);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IR_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIX       = 1'd1;

    // stream packing
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam logic FUNC_AUDIO = 1'b0;
    localparam logic FUNC_TAP   = 1'b1;

    // per-cycle strobes from the sequencer to both channel lanes
    typedef struct packed {
        logic start;     // frame transfer: capture dry sample, clear accumulator
        logic mul_en;    // memory read data valid
        logic mul_live;  // history entry has been written since the last clear
        logic acc_en;    // product register valid
        logic diff_en;   // accumulator final
        logic mix_en;    // wet minus dry valid
        logic out_en;    // load output register
    } lane_ctl_t;

    // memory port controls from the sequencer
    typedef struct packed {
        logic                  hist_we;
        logic [TAP_ADDR_W-1:0] hist_waddr;
        logic                  tap_we;
        logic                  rd_en;
        logic [TAP_ADDR_W-1:0] hist_raddr;
        logic [TAP_ADDR_W-1:0] tap_raddr;
    } mem_ctl_t;

    // clamp to the signed 16 bit range
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32767);
        lo = -WIDE_W'(32768);
        if (v > hi) begin
            return SAMPLE_W'(hi);
        end else if (v < lo) begin
            return SAMPLE_W'(lo);
        end else begin
            return SAMPLE_W'(v);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/sfcm_ram.sv
// generic simple dual-port ram with registered read data
`default_nettype none

module sfcm_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 12
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sfcm_lane.sv
// one channel datapath: multiply-accumulate, wet saturation and dry/wet mix
`default_nettype none

module sfcm_lane
    import sfcm_pkg::*;
(
    input  wire logic                       aclk,
    input  wire lane_ctl_t                  ctl,
    input  wire logic signed [SAMPLE_W-1:0] dry_sample,
    input  wire logic signed [SAMPLE_W-1:0] hist_sample,
    input  wire logic signed [SAMPLE_W-1:0] tap_value,
    input  wire logic        [MIX_W-1:0]    mix,
    output logic signed      [SAMPLE_W-1:0] out_sample
);

    logic signed [SAMPLE_W-1:0] dry_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DIFF_W-1:0]   diff_next;
    logic signed [SAMPLE_W-1:0] wet;
    logic signed [MIXP_W-1:0]   mixp_reg;
    logic signed [MIXP_W-1:0]   mixp_next;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic signed [SAMPLE_W-1:0] out_next;

    // product of one history sample and one tap, zero for a cleared entry
    assign prod_next = ctl.mul_live ? PROD_W'(hist_sample * tap_value) : '0;

    // wet = floor(acc / 2^15) saturated, then wet minus dry
    assign wet       = sat16(WIDE_W'(acc_reg >>> FRAC_BITS));
    assign diff_next = DIFF_W'(wet) - DIFF_W'(dry_reg);

    // scale the difference by the wet fraction
    assign mixp_next = MIXP_W'(diff_reg * $signed({1'b0, mix}));

    // dry plus scaled difference, saturated
    assign out_next  = sat16(WIDE_W'(mixp_reg >>> FRAC_BITS) + WIDE_W'(dry_reg));

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            dry_reg <= dry_sample;
        end
        if (ctl.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctl.start) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (ctl.diff_en) begin
            diff_reg <= diff_next;
        end
        if (ctl.mix_en) begin
            mixp_reg <= mixp_next;
        end
        if (ctl.out_en) begin
            out_reg <= out_next;
        end
    end

    assign out_sample = out_reg;

endmodule

`default_nettype wire

>>> rtl/sfcm_ctrl.sv
// sequencer: configuration registers, ring position, fill count and tap sweep
`default_nettype none

module sfcm_ctrl
    import sfcm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  func,
    output logic                       s_tready,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [MIX_W-1:0]           mix,
    output mem_ctl_t                   mem_ctl,
    output lane_ctl_t                  lane_ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_LOAD
    } state_t;

    state_t                state_reg, state_next;
    logic [TAP_ADDR_W-1:0] len_m1_reg, len_m1_next;
    logic [MIX_W-1:0]      mix_reg, mix_next;
    logic [TAP_ADDR_W-1:0] wp_reg, wp_next;
    logic [LEN_W-1:0]      fill_reg, fill_next;
    logic [TAP_ADDR_W-1:0] pos_reg, pos_next;
    logic [TAP_ADDR_W-1:0] j_reg, j_next;
    logic                  s1_valid_reg, s1_live_reg, s1_last_reg;
    logic                  s2_valid_reg, s2_last_reg;
    logic                  acc_done_reg, diff_done_reg, mix_done_reg;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic                  xfer;
    logic                  frame_xfer;
    logic                  tap_xfer;
    logic                  issue;
    logic                  issue_live;
    logic                  issue_last;
    logic                  out_free;
    logic                  out_load;
    logic [LEN_W-1:0]      len_cfg;
    logic [MIX_W-1:0]      mix_cfg;

    assign s_tready   = (state_reg == ST_IDLE);
    assign xfer       = s_tvalid && s_tready;
    assign frame_xfer = xfer && (func == FUNC_AUDIO);
    assign tap_xfer   = xfer && (func == FUNC_TAP);

    // tap sweep: newest sample meets tap 0, positions walk back around the ring
    assign issue      = (state_reg == ST_RUN);
    assign issue_live = {1'b0, pos_reg} < fill_reg;
    assign issue_last = (j_reg == len_m1_reg);

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_LOAD) && out_free;

    // register write values, clamped to their legal ranges
    always_comb begin
        len_cfg = cfg_data[LEN_W-1:0];
        if (len_cfg == '0) begin
            len_cfg = LEN_W'(1);
        end else if (len_cfg > LEN_W'(MAX_TAPS)) begin
            len_cfg = LEN_W'(MAX_TAPS);
        end
        mix_cfg = cfg_data[MIX_W-1:0];
        if (mix_cfg > MIX_MAX) begin
            mix_cfg = MIX_MAX;
        end
    end

    // next-state logic
    always_comb begin
        state_next    = state_reg;
        len_m1_next   = len_m1_reg;
        mix_next      = mix_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        m_tvalid_next = m_tvalid_reg;

        if (cfg_wr_en && (cfg_index == REG_IR_LENGTH)) begin
            len_m1_next = TAP_ADDR_W'(len_cfg - LEN_W'(1));
            wp_next     = '0;
            fill_next   = '0;
        end else if (cfg_wr_en && (cfg_index == REG_MIX)) begin
            mix_next = mix_cfg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (frame_xfer) begin
                    pos_next   = wp_reg;
                    j_next     = '0;
                    wp_next    = (wp_reg == len_m1_reg) ? '0 : wp_reg + TAP_ADDR_W'(1);
                    if (fill_reg != {1'b0, len_m1_reg} + LEN_W'(1)) begin
                        fill_next = fill_reg + LEN_W'(1);
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                pos_next = (pos_reg == '0) ? len_m1_reg : pos_reg - TAP_ADDR_W'(1);
                j_next   = j_reg + TAP_ADDR_W'(1);
                if (issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mix_done_reg) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // output register valid
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_m1_reg    <= '0;
            mix_reg       <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            j_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s1_live_reg   <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            acc_done_reg  <= 1'b0;
            diff_done_reg <= 1'b0;
            mix_done_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_m1_reg    <= len_m1_next;
            mix_reg       <= mix_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            j_reg         <= j_next;
            s1_valid_reg  <= issue;
            s1_live_reg   <= issue && issue_live;
            s1_last_reg   <= issue && issue_last;
            s2_valid_reg  <= s1_valid_reg;
            s2_last_reg   <= s1_valid_reg && s1_last_reg;
            acc_done_reg  <= s2_valid_reg && s2_last_reg;
            diff_done_reg <= acc_done_reg;
            mix_done_reg  <= diff_done_reg || (mix_done_reg && (state_reg == ST_DRAIN));
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // memory controls
    always_comb begin
        mem_ctl.hist_we    = frame_xfer;
        mem_ctl.hist_waddr = wp_reg;
        mem_ctl.tap_we     = tap_xfer;
        mem_ctl.rd_en      = issue;
        mem_ctl.hist_raddr = pos_reg;
        mem_ctl.tap_raddr  = j_reg;
    end

    // lane strobes
    always_comb begin
        lane_ctl.start    = frame_xfer;
        lane_ctl.mul_en   = s1_valid_reg;
        lane_ctl.mul_live = s1_live_reg;
        lane_ctl.acc_en   = s2_valid_reg;
        lane_ctl.diff_en  = acc_done_reg;
        lane_ctl.mix_en   = diff_done_reg;
        lane_ctl.out_en   = out_load;
    end

    assign m_tvalid = m_tvalid_reg;
    assign mix      = mix_reg;

    // the sweep stays inside the ring
    a_pos_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (pos_reg <= len_m1_reg))
        else $error("sweep position beyond ir length");

    // fill count never passes the ring length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= ({1'b0, len_m1_reg} + LEN_W'(1)))
        else $error("fill count beyond ir length");

    // memory read data only follows an issue cycle
    a_read_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> $past(state_reg == ST_RUN))
        else $error("read data flagged without an issue");

    // a finished frame lands in the output register
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctl.out_en |=> m_tvalid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> rtl/stereo_fir_convolution_mix.sv
// top level of the stereo direct-form fir convolution with dry/wet mix
//
//  channel   ports              contents
//  input     s_tvalid/s_tready  s_tdata, s_tuser: audio frame or one tap write
//  result    m_tvalid/m_tready  m_tdata: mixed left and right samples
//  config    cfg_wr_en          cfg_index, cfg_data: ir_length (0), mix (1)
//
// an audio frame does one multiply-accumulate per tap per cycle for both channels,
// read from the history and tap memories, plus pipeline drain. a finished result
// waits in the output register while the next item is taken. reset (aresetn low,
// synchronous) and an ir_length write empty both histories at once through the
// fill count; no clearing sweep is run.
`default_nettype none

module stereo_fir_convolution_mix
    import sfcm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // left_sample[15:0], right_sample[31:16], tap_index[43:32], tap_value[59:44], zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // func[0]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // left_out[15:0], right_out[31:16]
    output logic [M_TDATA_W-1:0]       m_tdata
);

    mem_ctl_t                   mem_ctl;
    lane_ctl_t                  lane_ctl;
    logic [MIX_W-1:0]           mix;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [TAP_ADDR_W-1:0]      tap_index;
    logic signed [SAMPLE_W-1:0] tap_value;
    logic [2*SAMPLE_W-1:0]      hist_rdata;
    logic [SAMPLE_W-1:0]        tap_rdata;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    // unpack the input transfer
    assign left_sample  = s_tdata[SAMPLE_W-1:0];
    assign right_sample = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign tap_index    = s_tdata[2*SAMPLE_W+TAP_ADDR_W-1:2*SAMPLE_W];
    assign tap_value    = s_tdata[3*SAMPLE_W+TAP_ADDR_W-1:2*SAMPLE_W+TAP_ADDR_W];

    // sequencer
    sfcm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .func      (s_tuser[0]),
        .s_tready  (s_tready),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .mix       (mix),
        .mem_ctl   (mem_ctl),
        .lane_ctl  (lane_ctl)
    );

    // stereo history ring, right in the upper half
    sfcm_ram #(
        .DATA_W (2 * SAMPLE_W),
        .ADDR_W (TAP_ADDR_W)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (mem_ctl.hist_we),
        .waddr (mem_ctl.hist_waddr),
        .wdata ({right_sample, left_sample}),
        .re    (mem_ctl.rd_en),
        .raddr (mem_ctl.hist_raddr),
        .rdata (hist_rdata)
    );

    // impulse response taps
    sfcm_ram #(
        .DATA_W (SAMPLE_W),
        .ADDR_W (TAP_ADDR_W)
    ) u_tap_ram (
        .aclk  (aclk),
        .we    (mem_ctl.tap_we),
        .waddr (tap_index),
        .wdata (tap_value),
        .re    (mem_ctl.rd_en),
        .raddr (mem_ctl.tap_raddr),
        .rdata (tap_rdata)
    );

    // left channel
    sfcm_lane u_lane_left (
        .aclk        (aclk),
        .ctl         (lane_ctl),
        .dry_sample  (left_sample),
        .hist_sample (hist_rdata[SAMPLE_W-1:0]),
        .tap_value   (tap_rdata),
        .mix         (mix),
        .out_sample  (left_out)
    );

    // right channel
    sfcm_lane u_lane_right (
        .aclk        (aclk),
        .ctl         (lane_ctl),
        .dry_sample  (right_sample),
        .hist_sample (hist_rdata[2*SAMPLE_W-1:SAMPLE_W]),
        .tap_value   (tap_rdata),
        .mix         (mix),
        .out_sample  (right_out)
    );

    assign m_tdata = {right_out, left_out};

endmodule

`default_nettype wire
